[rtl/core/bfba_pkg.sv]
// ----------------------------------------------------------------------------
// bfba_pkg: shared types and constants of the best-fit block allocator
// Field widths, result codes, state encoding and the control and status
// groups that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package bfba_pkg;

    localparam int AMOUNT_W = 16;
    localparam int SIZE_W   = 16;
    localparam int ENTRY_W  = SIZE_W + 1;   // in-use mark above the size
    localparam int STATUS_W = 2;
    localparam int OUT_IDX_W = 6;
    localparam int OUT_DATA_W = 24;         // index and size, padded to bytes

    localparam logic KIND_LOAD    = 1'b0;
    localparam logic KIND_REQUEST = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_LOADED    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_ALLOCATED = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_NO_FIT    = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_SCAN,
        ST_DRAIN,
        ST_ALLOC
    } state_t;

    typedef struct packed {
        logic accept;
        logic scan_issue;
        logic load_commit;
        logic alloc_commit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic out_free;
        logic scan_last;
        logic table_empty;
        logic table_full;
    } dp_status_t;

endpackage

[rtl/core/bfba_ram.sv]
// ----------------------------------------------------------------------------
// bfba_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module bfba_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 64,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/core/bfba_ctrl.sv]
// ----------------------------------------------------------------------------
// bfba_ctrl: controller of the best-fit block allocator
// Sequences item acceptance, the table scan and the commit of each result.
// ----------------------------------------------------------------------------
module bfba_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_kind,
    output logic                 in_ready,
    input  bfba_pkg::dp_status_t status,
    output bfba_pkg::ctrl_cmd_t  cmd
);

    bfba_pkg::state_t state_reg;
    bfba_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bfba_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            bfba_pkg::ST_IDLE:
            begin
                // No transfer is taken while reset is held.
                in_ready = rst_n;
                if (in_valid && rst_n)
                begin
                    cmd.accept = 1'b1;
                    if (in_kind == bfba_pkg::KIND_LOAD)
                    begin
                        state_next = bfba_pkg::ST_LOAD;
                    end
                    else if (status.table_empty)
                    begin
                        state_next = bfba_pkg::ST_ALLOC;
                    end
                    else
                    begin
                        state_next = bfba_pkg::ST_SCAN;
                    end
                end
            end
            bfba_pkg::ST_LOAD:
            begin
                if (status.out_free)
                begin
                    cmd.load_commit = 1'b1;
                    state_next      = bfba_pkg::ST_IDLE;
                end
            end
            bfba_pkg::ST_SCAN:
            begin
                cmd.scan_issue = 1'b1;
                if (status.scan_last)
                begin
                    state_next = bfba_pkg::ST_DRAIN;
                end
            end
            bfba_pkg::ST_DRAIN:
            begin
                // The last read returns and is compared in this cycle.
                state_next = bfba_pkg::ST_ALLOC;
            end
            bfba_pkg::ST_ALLOC:
            begin
                if (status.out_free)
                begin
                    cmd.alloc_commit = 1'b1;
                    state_next       = bfba_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = bfba_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

[rtl/core/bfba_dp.sv]
// ----------------------------------------------------------------------------
// bfba_dp: datapath of the best-fit block allocator
// Holds the block table, the fill count, the best-fit search registers and
// the output register.
// ----------------------------------------------------------------------------
module bfba_dp #(
    parameter int BLOCKS = 64
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  bfba_pkg::ctrl_cmd_t                 cmd,
    output bfba_pkg::dp_status_t                status,
    input  logic [bfba_pkg::AMOUNT_W-1:0]       in_amount,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [bfba_pkg::OUT_DATA_W-1:0]     out_data,
    output logic [bfba_pkg::STATUS_W-1:0]       out_status
);

    localparam int IDX_W = $clog2(BLOCKS);
    localparam int CNT_W = $clog2(BLOCKS + 1);

    logic [CNT_W-1:0]                 count_reg, count_next;
    logic [CNT_W-1:0]                 scan_idx_reg, scan_idx_next;
    logic                             rd_pend_reg, rd_pend_next;
    logic [IDX_W-1:0]                 rd_idx_reg, rd_idx_next;
    logic                             found_reg, found_next;
    logic [IDX_W-1:0]                 best_idx_reg, best_idx_next;
    logic [bfba_pkg::SIZE_W-1:0]      best_size_reg, best_size_next;
    logic [bfba_pkg::AMOUNT_W-1:0]    amount_reg, amount_next;
    logic                             out_valid_reg, out_valid_next;
    logic [bfba_pkg::STATUS_W-1:0]    out_status_reg, out_status_next;
    logic [bfba_pkg::OUT_IDX_W-1:0]   out_index_reg, out_index_next;
    logic [bfba_pkg::SIZE_W-1:0]      out_bytes_reg, out_bytes_next;

    logic                             wr_en;
    logic [IDX_W-1:0]                 wr_addr;
    logic [bfba_pkg::ENTRY_W-1:0]     wr_data;
    logic [bfba_pkg::ENTRY_W-1:0]     rd_data;
    logic [bfba_pkg::SIZE_W-1:0]      rd_size;
    logic                             hit;
    logic [31:0]                      count_ext;
    logic [31:0]                      best_ext;

    bfba_ram #(
        .WIDTH (bfba_pkg::ENTRY_W),
        .DEPTH (BLOCKS)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (cmd.scan_issue),
        .rd_addr (scan_idx_reg[IDX_W-1:0]),
        .rd_data (rd_data)
    );

    assign status.out_free    = !out_valid_reg || out_ready;
    assign status.table_empty = (count_reg == '0);
    assign status.table_full  = (count_reg == CNT_W'(BLOCKS));
    assign status.scan_last   = (scan_idx_reg == count_reg - CNT_W'(1));

    assign rd_size   = rd_data[bfba_pkg::SIZE_W-1:0];
    assign count_ext = 32'(count_reg);
    assign best_ext  = 32'(best_idx_reg);

    // Strict less-than keeps the lowest index among equal sizes.
    assign hit = rd_pend_reg && !rd_data[bfba_pkg::SIZE_W]
                 && (rd_size >= amount_reg)
                 && (!found_reg || (rd_size < best_size_reg));

    always_comb
    begin
        count_next      = count_reg;
        scan_idx_next   = scan_idx_reg;
        rd_pend_next    = 1'b0;
        rd_idx_next     = rd_idx_reg;
        found_next      = found_reg;
        best_idx_next   = best_idx_reg;
        best_size_next  = best_size_reg;
        amount_next     = amount_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_status_next = out_status_reg;
        out_index_next  = out_index_reg;
        out_bytes_next  = out_bytes_reg;
        wr_en           = 1'b0;
        wr_addr         = count_reg[IDX_W-1:0];
        wr_data         = {1'b0, amount_reg};

        if (cmd.accept)
        begin
            amount_next   = in_amount;
            found_next    = 1'b0;
            scan_idx_next = '0;
        end

        if (cmd.scan_issue)
        begin
            scan_idx_next = scan_idx_reg + CNT_W'(1);
            rd_pend_next  = 1'b1;
            rd_idx_next   = scan_idx_reg[IDX_W-1:0];
        end

        if (hit)
        begin
            found_next     = 1'b1;
            best_idx_next  = rd_idx_reg;
            best_size_next = rd_size;
        end

        if (cmd.load_commit)
        begin
            out_valid_next = 1'b1;
            out_bytes_next = '0;
            if (status.table_full)
            begin
                out_status_next = bfba_pkg::STATUS_FULL;
                out_index_next  = '0;
            end
            else
            begin
                // A new entry always starts free.
                wr_en           = 1'b1;
                count_next      = count_reg + CNT_W'(1);
                out_status_next = bfba_pkg::STATUS_LOADED;
                out_index_next  = count_ext[bfba_pkg::OUT_IDX_W-1:0];
            end
        end

        if (cmd.alloc_commit)
        begin
            out_valid_next = 1'b1;
            wr_addr        = best_idx_reg;
            wr_data        = {1'b1, best_size_reg};
            if (found_reg)
            begin
                wr_en           = 1'b1;
                out_status_next = bfba_pkg::STATUS_ALLOCATED;
                out_index_next  = best_ext[bfba_pkg::OUT_IDX_W-1:0];
                out_bytes_next  = best_size_reg;
            end
            else
            begin
                out_status_next = bfba_pkg::STATUS_NO_FIT;
                out_index_next  = '0;
                out_bytes_next  = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            scan_idx_reg  <= '0;
            rd_pend_reg   <= 1'b0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            scan_idx_reg  <= scan_idx_next;
            rd_pend_reg   <= rd_pend_next;
            found_reg     <= found_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_idx_reg     <= rd_idx_next;
        best_idx_reg   <= best_idx_next;
        best_size_reg  <= best_size_next;
        amount_reg     <= amount_next;
        out_status_reg <= out_status_next;
        out_index_reg  <= out_index_next;
        out_bytes_reg  <= out_bytes_next;
    end

    assign out_valid  = out_valid_reg;
    assign out_status = out_status_reg;
    assign out_data   = {{(bfba_pkg::OUT_DATA_W - bfba_pkg::SIZE_W - bfba_pkg::OUT_IDX_W){1'b0}},
                         out_bytes_reg, out_index_reg};

    a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(BLOCKS))
        else $error("fill count exceeds the table depth");

    a_commit_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.load_commit || cmd.alloc_commit) |-> status.out_free)
        else $error("result committed while the output register is occupied");

    a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.scan_issue |-> (scan_idx_reg < count_reg))
        else $error("scan read issued beyond the loaded entries");

    a_best_fits: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.alloc_commit && found_reg) |-> (best_size_reg >= amount_reg))
        else $error("chosen block is smaller than the request");

    a_alloc_result: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.alloc_commit && found_reg) |=>
            (out_valid_reg && out_status_reg == bfba_pkg::STATUS_ALLOCATED))
        else $error("allocation did not produce an allocated result");

endmodule

[rtl/core/best_fit_block_allocator_unit.sv]
// ----------------------------------------------------------------------------
// best_fit_block_allocator_unit: best-fit allocator over a table of blocks
// Input items on the s_ channel either load a block size into the table or
// request the smallest free block at least as large as the amount given.
// Every item gives exactly one result on the m_ channel: its status in
// m_tuser, the block index and size in m_tdata.
// A load waits in the LOAD state until the output register is free and is
// then committed. A request reads the table once per loaded entry through
// the single read port of the table RAM, then drains the last read and
// commits; a request on an empty table skips the scan.
// One item is worked on at a time; s_tready is high only between items.
// The result sits in an output register, so the next item is taken while
// it waits; if the receiver stalls, the following result is held until
// that register is free.
// Reset empties the table and drops any pending result; no clearing pass
// is needed, as entries above the fill count are never read.
// ----------------------------------------------------------------------------
module best_fit_block_allocator_unit #(
    parameter int BLOCKS = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] amount
    input  logic [0:0]  s_tuser,   // [0] kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [5:0] block_index, [21:6] block_bytes, [23:22] zero
    output logic [1:0]  m_tuser    // [1:0] status
);

    bfba_pkg::ctrl_cmd_t  cmd;
    bfba_pkg::dp_status_t status;

    bfba_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_kind  (s_tuser[0]),
        .in_ready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    bfba_dp #(
        .BLOCKS (BLOCKS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .in_amount  (s_tdata),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_data   (m_tdata),
        .out_status (m_tuser)
    );

endmodule

[tb/best_fit_block_allocator_unit_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// best_fit_block_allocator_unit_tb: self-checking bench for the allocator
// Loads block sizes and sends allocation requests over the s_ stream. A table
// model in the bench works out the reply to every accepted item, and each
// reply on the m_ stream is compared with it. Both sides stall at random,
// the receiver once holds off long enough to back up the input, and the
// table is filled to the brim before the run ends.
// ----------------------------------------------------------------------------
module best_fit_block_allocator_unit_tb;

    localparam int TABLE_DEPTH = 64;
    localparam int LONG_HOLD   = 400;
    localparam int TAIL_CYCLES = TABLE_DEPTH + 16;

    typedef struct packed {
        logic [bfba_pkg::STATUS_W-1:0]  status;
        logic [bfba_pkg::OUT_IDX_W-1:0] index;
        logic [bfba_pkg::SIZE_W-1:0]    bytes;
    } reply_t;

    // Tracks the block table and the in-use marks, and holds the replies the
    // block still owes in the order in which the items were taken.
    class block_table_model;
        logic [bfba_pkg::SIZE_W-1:0] sizes [TABLE_DEPTH];
        bit                          taken [TABLE_DEPTH];
        int                          count;
        int                          errors;
        reply_t                      replies_due [$];

        function new();
            count  = 0;
            errors = 0;
            foreach (taken[i])
                taken[i] = 1'b0;
        endfunction

        function void note_item(logic kind, logic [bfba_pkg::AMOUNT_W-1:0] amount);
            reply_t r;
            int     best;
            r = '0;
            if (kind == bfba_pkg::KIND_LOAD)
            begin
                if (count >= TABLE_DEPTH)
                    r.status = bfba_pkg::STATUS_FULL;
                else
                begin
                    sizes[count] = amount;
                    taken[count] = 1'b0;
                    r.status     = bfba_pkg::STATUS_LOADED;
                    r.index      = count[bfba_pkg::OUT_IDX_W-1:0];
                    count++;
                end
            end
            else
            begin
                // Strict less-than keeps the lowest index on equal sizes.
                best = -1;
                for (int i = 0; i < count; i++)
                    if (!taken[i] && sizes[i] >= amount &&
                        (best < 0 || sizes[i] < sizes[best]))
                        best = i;
                if (best < 0)
                    r.status = bfba_pkg::STATUS_NO_FIT;
                else
                begin
                    taken[best] = 1'b1;
                    r.status    = bfba_pkg::STATUS_ALLOCATED;
                    r.index     = best[bfba_pkg::OUT_IDX_W-1:0];
                    r.bytes     = sizes[best];
                end
            end
            replies_due.push_back(r);
        endfunction

        function void check_reply(logic [bfba_pkg::STATUS_W-1:0] status,
                                  logic [bfba_pkg::OUT_IDX_W-1:0] index,
                                  logic [bfba_pkg::SIZE_W-1:0] bytes);
            reply_t want;
            if (replies_due.size() == 0)
            begin
                $display("%0t: reply with none awaited: status %0d index %0d bytes %0d",
                         $time, status, index, bytes);
                errors++;
                return;
            end
            want = replies_due.pop_front();
            if (want.status !== status)
            begin
                $display("%0t: status mismatch: expected %0d, got %0d", $time, want.status, status);
                errors++;
            end
            if (want.index !== index)
            begin
                $display("%0t: block_index mismatch: expected %0d, got %0d",
                         $time, want.index, index);
                errors++;
            end
            if (want.bytes !== bytes)
            begin
                $display("%0t: block_bytes mismatch: expected %0d, got %0d",
                         $time, want.bytes, bytes);
                errors++;
            end
        endfunction

        function int pending();
            return replies_due.size();
        endfunction

        function logic [bfba_pkg::SIZE_W-1:0] some_loaded_size();
            if (count == 0)
                return '0;
            return sizes[$urandom_range(0, count - 1)];
        endfunction
    endclass

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [15:0]         s_tdata = '0;
    logic [0:0]          s_tuser = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [23:0]         m_tdata;
    logic [1:0]          m_tuser;

    block_table_model    tracker;
    int                  send_idle_pct = 0;
    int                  recv_idle_pct = 0;
    int                  hold_req = 0;
    int                  hold_seen = 0;
    int                  hold_left = 0;

    best_fit_block_allocator_unit #(
        .BLOCKS(TABLE_DEPTH)
    ) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #5 clk = ~clk;

    initial
    begin
        #10_000_000;
        $display("TEST FAILED");
        $finish;
    end

    // Receiver: checks each transfer and decides tready for the next edge.
    always @(posedge clk)
    begin
        if (m_tvalid && m_tready)
            tracker.check_reply(m_tuser, m_tdata[5:0], m_tdata[21:6]);
        if (hold_req != hold_seen)
        begin
            hold_seen <= hold_req;
            hold_left <= LONG_HOLD;
            m_tready  <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    task automatic send_item(input logic kind, input logic [bfba_pkg::AMOUNT_W-1:0] amount);
        while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= amount;
        s_tuser  <= kind;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        tracker.note_item(kind, amount);
    endtask

    task automatic send_random(input int n);
        logic [bfba_pkg::AMOUNT_W-1:0] amount;
        logic [bfba_pkg::SIZE_W-1:0]   sz;
        int                            d;
        int                            pick;
        repeat (n)
        begin
            if ($urandom_range(0, 99) < 3)
            begin
                pick = $urandom_range(0, 3);
                if (pick < 2)
                    amount = 16'($urandom_range(0, 65535));
                else if (pick == 2)
                    amount = 16'($urandom_range(0, 255));
                else
                    amount = tracker.some_loaded_size();
                send_item(bfba_pkg::KIND_LOAD, amount);
            end
            else
            begin
                pick = $urandom_range(0, 19);
                if (pick < 3)
                    amount = '0;
                else if (pick < 5)
                    amount = '1;
                else if (pick < 13)
                begin
                    // Aim near a stored size so that the best-fit choice matters.
                    sz = tracker.some_loaded_size();
                    d  = $urandom_range(0, 2);
                    if ($urandom_range(0, 3) == 0 && sz != '1)
                        amount = sz + 1'b1;
                    else
                        amount = (sz >= d) ? sz - d[bfba_pkg::SIZE_W-1:0] : '0;
                end
                else
                    amount = 16'($urandom_range(0, 65535));
                send_item(bfba_pkg::KIND_REQUEST, amount);
            end
        end
    endtask

    task automatic drain_replies();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (tracker.pending() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        tracker = new();
        repeat (10)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 24;
        recv_idle_pct = 69;

        // Requests on an empty table find nothing.
        send_item(bfba_pkg::KIND_REQUEST, 16'h0000);
        send_item(bfba_pkg::KIND_REQUEST, 16'hFFFF);
        send_item(bfba_pkg::KIND_LOAD, 16'h0000);
        send_item(bfba_pkg::KIND_LOAD, 16'hFFFF);
        send_item(bfba_pkg::KIND_LOAD, 16'd100);
        send_item(bfba_pkg::KIND_LOAD, 16'd100);
        send_item(bfba_pkg::KIND_LOAD, 16'd50);
        send_item(bfba_pkg::KIND_LOAD, 16'hAAAA);
        send_item(bfba_pkg::KIND_LOAD, 16'h5555);
        // A zero request takes the smallest free block, whatever its size.
        send_item(bfba_pkg::KIND_REQUEST, 16'h0000);
        send_item(bfba_pkg::KIND_REQUEST, 16'h0000);
        // Equal sizes: the lower index goes first.
        send_item(bfba_pkg::KIND_REQUEST, 16'd100);
        send_item(bfba_pkg::KIND_REQUEST, 16'd100);
        send_item(bfba_pkg::KIND_REQUEST, 16'd100);
        send_item(bfba_pkg::KIND_REQUEST, 16'hFFFF);
        send_item(bfba_pkg::KIND_REQUEST, 16'hFFFF);
        send_item(bfba_pkg::KIND_REQUEST, 16'hAAAB);
        send_item(bfba_pkg::KIND_REQUEST, 16'h0001);
        // Every block is now in use.
        send_item(bfba_pkg::KIND_REQUEST, 16'h0000);

        send_random(630);
        drain_replies();

        send_idle_pct = 69;
        recv_idle_pct = 24;
        send_random(630);
        drain_replies();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_req <= hold_req + 1;
        send_random(620);

        // Fill whatever is left of the table, then overrun it.
        while (tracker.count < TABLE_DEPTH)
            send_item(bfba_pkg::KIND_LOAD, 16'($urandom_range(0, 65535)));
        repeat (3)
            send_item(bfba_pkg::KIND_LOAD, 16'($urandom_range(0, 65535)));
        send_item(bfba_pkg::KIND_REQUEST, 16'h0000);
        send_item(bfba_pkg::KIND_REQUEST, 16'h0000);
        drain_replies();

        repeat (TAIL_CYCLES)
            @(posedge clk);
        if (tracker.errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

[filelist.f]
rtl/core/bfba_pkg.sv
rtl/core/bfba_ram.sv
rtl/core/bfba_ctrl.sv
rtl/core/bfba_dp.sv
rtl/core/best_fit_block_allocator_unit.sv
tb/best_fit_block_allocator_unit_tb.sv
